>>> sv/pil_pkg.sv
// ----------------------------------------------------------------------------
// pil_pkg
// Shared types, widths and command codes for the positional insert/extract
// list: a cell chain that keeps an ordered list of signed words.
// ----------------------------------------------------------------------------
package pil_pkg;

  // Default list capacity
  localparam int DEPTH_DEF = 16;

  // Field widths of one command and one result
  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int CNT_O_W  = 5;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((POS_W + WORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WORD_W + CNT_O_W + 7) / 8) * 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EXTRACT_AT = 3'd5;

  // Decoded operation broadcast to every cell
  typedef struct packed {
    logic ok;   // command succeeds
    logic ins;  // open a gap at the target index
    logic rem;  // close the gap at the target index
  } op_t;

endpackage

>>> sv/pil_cell.sv
// ----------------------------------------------------------------------------
// pil_cell
// One list slot. Holds a word and, on an insert or remove, loads from its
// left neighbor, the new word or its right neighbor.
// ----------------------------------------------------------------------------
module pil_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic                       clk,
  input  pil_pkg::op_t               op,
  input  logic [IDX_W-1:0]           tgt_idx,
  input  logic [pil_pkg::WORD_W-1:0] word_in,
  input  logic [pil_pkg::WORD_W-1:0] left_val,
  input  logic [pil_pkg::WORD_W-1:0] right_val,
  output logic [pil_pkg::WORD_W-1:0] val,
  output logic                       hit
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [pil_pkg::WORD_W-1:0] val_r;
  logic [pil_pkg::WORD_W-1:0] val_nxt;
  logic                       above;

  assign above = MY_IDX > tgt_idx;
  assign hit   = MY_IDX == tgt_idx;
  assign val   = val_r;

  // Select shift source
  always_comb begin
    val_nxt = val_r;
    if (op.ok && op.ins) begin
      if (above) begin
        val_nxt = left_val;
      end else if (hit) begin
        val_nxt = word_in;
      end
    end else if (op.ok && op.rem) begin
      if (above || hit) begin
        val_nxt = right_val;
      end
    end
  end

  // Hold list word
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

>>> sv/pil_ctrl.sv
// ----------------------------------------------------------------------------
// pil_ctrl
// Command decoder: checks the command against the fill count and gives the
// operation and the target index for the cell row.
// ----------------------------------------------------------------------------
module pil_ctrl #(
  parameter int DEPTH = pil_pkg::DEPTH_DEF,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic [pil_pkg::CMD_W-1:0] cmd,
  input  logic [pil_pkg::POS_W-1:0] pos,
  input  logic [CNT_W-1:0]          count,
  output pil_pkg::op_t              op,
  output logic [IDX_W-1:0]          tgt_idx
);

  localparam int CMP_W = (CNT_W > pil_pkg::POS_W) ? CNT_W : pil_pkg::POS_W;

  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CNT_W-1:0] last;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign pos_x = CMP_W'(pos);
  assign cnt_x = CMP_W'(count);
  assign last  = count - CNT_W'(1);

  // Decode command
  always_comb begin
    op      = '0;
    tgt_idx = '0;
    unique case (cmd)
      pil_pkg::CMD_PUSH_BACK: begin
        op.ins  = 1'b1;
        op.ok   = !full;
        tgt_idx = IDX_W'(count);
      end
      pil_pkg::CMD_POP_BACK: begin
        op.rem  = 1'b1;
        op.ok   = !empty;
        tgt_idx = IDX_W'(last);
      end
      pil_pkg::CMD_PUSH_FRONT: begin
        op.ins  = 1'b1;
        op.ok   = !full;
      end
      pil_pkg::CMD_POP_FRONT: begin
        op.rem  = 1'b1;
        op.ok   = !empty;
      end
      pil_pkg::CMD_INSERT_AT: begin
        op.ins  = 1'b1;
        op.ok   = !full && (pos_x <= cnt_x);
        tgt_idx = IDX_W'(pos);
      end
      pil_pkg::CMD_EXTRACT_AT: begin
        op.rem  = 1'b1;
        op.ok   = pos_x < cnt_x;
        tgt_idx = IDX_W'(pos);
      end
      default: begin
        op = '0;
      end
    endcase
  end

endmodule

>>> sv/positional_insert_extract_list_core.sv
// ----------------------------------------------------------------------------
// positional_insert_extract_list_core
// Ordered list of signed words in a row of shifting cells, with push and pop
// at both ends and insert or extract at any position.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one command per transfer: in_tuser carries the
//   command code, in_tdata the position and the word to insert. Every
//   command gives exactly one result on the out_ channel: out_tuser is the
//   ok flag, out_tdata the removed word (zero unless a pop or extract
//   succeeds) and the count after the command.
//   The result is registered, valid in the cycle after the input transfer.
//   Throughput is one command per cycle unless a result stalls: all cells
//   shift or load in parallel in the cycle of the transfer, and the fill
//   count register feeds the next command's range check in the next cycle.
//   The result sits in an output register; a new command is taken while
//   that result is being transferred, and in_tready drops only while a
//   result waits on a stalled receiver.
//   Reset empties the list (count zero) and drops out_tvalid. The cell
//   contents are not cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_extract_list_core #(
  parameter int DEPTH = pil_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Command channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pil_pkg::IN_DATA_W-1:0]  in_tdata,  // [4:0] position, [36:5] value_in
  input  logic [pil_pkg::CMD_W-1:0]      in_tuser,  // [2:0] command
  // Result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pil_pkg::OUT_DATA_W-1:0] out_tdata, // [31:0] value_out, [36:32] count
  output logic                           out_tuser  // [0] ok
);

  localparam int W     = pil_pkg::WORD_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > pil_pkg::CNT_O_W) ? CNT_W : pil_pkg::CNT_O_W;

  logic                         in_xfer;
  logic [pil_pkg::POS_W-1:0]    pos;
  logic [W-1:0]                 word;
  pil_pkg::op_t                 op;
  pil_pkg::op_t                 op_g;
  logic [IDX_W-1:0]             tgt_idx;
  logic [W-1:0]                 vals [DEPTH];
  logic [DEPTH-1:0]             hits;
  logic [W-1:0]                 removed;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [CMP_W-1:0]             count_x;
  logic                         out_valid_r;
  logic                         out_ok_r;
  logic [W-1:0]                 out_value_r;
  logic [pil_pkg::CNT_O_W-1:0]  out_count_r;

  assign pos       = in_tdata[pil_pkg::POS_W-1:0];
  assign word      = in_tdata[pil_pkg::POS_W +: W];
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Decode command against current count
  pil_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .cmd     (in_tuser),
    .pos     (pos),
    .count   (count_r),
    .op      (op),
    .tgt_idx (tgt_idx)
  );

  // Act only on a transfer
  always_comb begin
    op_g    = op;
    op_g.ok = op.ok && in_xfer;
  end

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] left_v;
    logic [W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = vals[i];
    end else begin : g_left
      assign left_v = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_right
      assign right_v = vals[i+1];
    end
    pil_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .op        (op_g),
      .tgt_idx   (tgt_idx),
      .word_in   (word),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (vals[i]),
      .hit       (hits[i])
    );
  end

  // Pick removed word from the target cell
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | (hits[i] ? vals[i] : '0);
    end
  end

  // Next fill count
  always_comb begin
    count_nxt = count_r;
    if (op_g.ok && op_g.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op_g.ok && op_g.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_x = CMP_W'(count_nxt);

  // Advance count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_ok_r    <= op.ok;
      out_value_r <= (op.ok && op.rem) ? removed : '0;
      out_count_r <= count_x[pil_pkg::CNT_O_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = pil_pkg::OUT_DATA_W'({out_count_r, out_value_r});

endmodule

>>> sv/pil_checker.sv
// ----------------------------------------------------------------------------
// pil_checker
// Port-level checks on the list core: result timing, stall hold and the
// shape of failed results.
// ----------------------------------------------------------------------------
module pil_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pil_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);

  // Reset drops the result
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Every command transfer gives a result in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result one cycle after command transfer");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A failed command removes nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[pil_pkg::WORD_W-1:0] == '0)
    else $error("failed command returned a nonzero word");

endmodule

bind positional_insert_extract_list_core pil_checker u_pil_checker (.*);
